/* rtl/ffc_pkg.sv */
// Shared types, constants and tables for the fractional feedback comb.
package ffc_pkg;

   localparam int unsigned CFG_IDX_W = 2;
   localparam int unsigned CFG_DATA_W = 20;

   localparam logic [CFG_IDX_W-1:0] CSR_SAMPLES_PER_MS = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_MAX_DELAY_MS   = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_GAIN_MODE      = 2'd2;

   localparam logic [15:0] SAMPLES_PER_MS_RESET = 16'd12288;

   localparam logic       CMD_PROCESS = 1'b0;
   localparam logic       CMD_CLEAR   = 1'b1;
   localparam logic       MODE_DECAY  = 1'b0;
   localparam logic       MODE_DIRECT = 1'b1;

   localparam int unsigned DELAY_W = 20;
   localparam int unsigned COEF_W = 24;
   localparam int unsigned EXP_BITS = 10;
   localparam logic [20:0] LOG2_1000_Q16 = 21'd653118;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [5:0]  MAX_EXP_SHIFT = 6'd40;

   typedef enum logic [19:0] {
      ST_CLEAR  = 20'b00000000000000000001,
      ST_IDLE   = 20'b00000000000000000010,
      ST_RMUL   = 20'b00000000000000000100,
      ST_RLOAD  = 20'b00000000000000001000,
      ST_QMUL   = 20'b00000000000000010000,
      ST_MOD    = 20'b00000000000000100000,
      ST_ADDR   = 20'b00000000000001000000,
      ST_RDA    = 20'b00000000000010000000,
      ST_RDB    = 20'b00000000000100000000,
      ST_IMUL   = 20'b00000000001000000000,
      ST_INTERP = 20'b00000000010000000000,
      ST_DIV    = 20'b00000000100000000000,
      ST_EMUL   = 20'b00000001000000000000,
      ST_ELOAD  = 20'b00000010000000000000,
      ST_EXPM   = 20'b00000100000000000000,
      ST_EXPR   = 20'b00001000000000000000,
      ST_GAIN   = 20'b00010000000000000000,
      ST_GMUL   = 20'b00100000000000000000,
      ST_ACC    = 20'b01000000000000000000,
      ST_DONE   = 20'b10000000000000000000
   } state_type;

   // 2^-(2^-(k+1)) in Q16, for k = 0 .. EXP_BITS-1
   function automatic logic [16:0] exp2_neg(input logic [3:0] k);
      logic [16:0] v;
      case (k)
         4'd0:    v = 17'd46341;
         4'd1:    v = 17'd55109;
         4'd2:    v = 17'd60097;
         4'd3:    v = 17'd62757;
         4'd4:    v = 17'd64132;
         4'd5:    v = 17'd64830;
         4'd6:    v = 17'd65182;
         4'd7:    v = 17'd65359;
         4'd8:    v = 17'd65447;
         4'd9:    v = 17'd65492;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

/* rtl/fractional_feedback_comb.sv */
// Fractional feedback comb filter with a linearly interpolated delay store.
//
// Input beats (req_*) carry a command, a sample, a delay and a coefficient.
// A process beat yields one rsp_* beat; a clear beat yields none and zeroes
// the store and write position with a sweep over every store address.
// Configuration is written through csr_we/csr_index/csr_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
// One multiplier is shared by every product under a small sequencer; the
// store wrap is a reciprocal multiply with one correcting subtract, and a
// one-bit-per-cycle subtractor does the decay divide in 36 steps, followed
// by 10 exp2 factors; direct gain mode or a zero coefficient skips both.
// One beat is in flight at a time; req_ready is high only when the
// sequencer is idle.
// After reset the store is swept clear over every address before the
// first beat is taken; configuration writes are taken throughout.
// A finished sample sits in the output register; if the receiver stalls,
// the next beat may still be accepted and computed, and it waits in its
// last step until the output register frees.
module fractional_feedback_comb
   import ffc_pkg::*;
#(
   parameter int unsigned DELAY_DEPTH = 65536,
   parameter int unsigned SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [DELAY_W-1:0]             req_delay_ms,
   input  logic signed [COEF_W-1:0]       req_coef,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                           csr_we,
   input  logic [CFG_IDX_W-1:0]           csr_index,
   input  logic [CFG_DATA_W-1:0]          csr_wdata
);

   localparam int unsigned SW = SAMPLE_WIDTH;
   localparam int unsigned AW = (DELAY_DEPTH > 2) ? $clog2(DELAY_DEPTH) : 1;
   localparam int unsigned MA = (SW + 2 > 37) ? SW + 2 : 37;
   localparam int unsigned MB = (SW > 21) ? SW : 21;
   localparam int unsigned PW = MA + MB;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
   localparam logic [DELAY_W:0] DEPTH_R = (DELAY_W + 1)'(DELAY_DEPTH);
   localparam logic [DELAY_W:0] RECIP_Q20 = (DELAY_W + 1)'((1 << DELAY_W) / DELAY_DEPTH);
   localparam logic [AW+1:0] DEPTH_X = (AW + 2)'(DELAY_DEPTH);
   localparam logic signed [PW:0] SMAX = {{(PW - SW + 2){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [PW:0] SMIN = {{(PW - SW + 2){1'b1}}, {(SW - 1){1'b0}}};

   state_type state_ff, state_in;

   logic [15:0]        spm_ff;
   logic [DELAY_W-1:0] max_delay_ff;
   logic               mode_ff;

   logic signed [SW-1:0]     x_ff;
   logic [DELAY_W-1:0]       d_ff;
   logic signed [COEF_W-1:0] coef_ff;
   logic [AW-1:0]            wp_ff;
   logic [AW-1:0]            clr_addr_ff;
   logic [5:0]               cnt_ff;
   logic [DELAY_W-1:0]       rint_ff;
   logic [15:0]              rfrac_ff;
   logic [AW:0]              rem_ff;
   logic [AW-1:0]            i1_ff, i2_ff;
   logic [16:0]              f_ff;
   logic signed [SW-1:0]     rd_ff, a_ff, y_ff;
   logic [35:0]              div_num_ff;
   logic [22:0]              div_rem_ff;
   logic [23:0]              mag_ff;
   logic [EXP_BITS-1:0]      frac_ff;
   logic [5:0]               n_ff;
   logic                     nbig_ff;
   logic [16:0]              m_ff;
   logic signed [COEF_W-1:0] g_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [SW-1:0]     acc_ff;
   logic                     rsp_valid_ff;
   logic signed [SW-1:0]     rsp_data_ff;

   logic signed [SW-1:0] store_mem [DELAY_DEPTH];

   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;

   logic [35:0]          r_full;
   logic [DELAY_W:0]     mod_raw;
   logic [DELAY_W:0]     mod_fix;
   logic [AW+1:0]        pos_raw;
   logic [AW+1:0]        pos_wrap;
   logic [AW-1:0]        i1_next;
   logic signed [PW-1:0] interp_sh;
   logic signed [SW:0]   y_sum;
   logic [23:0]          div_trial;
   logic [32:0]          m_round;
   logic [20:0]          g_mag;
   logic signed [PW-1:0] out_sh;
   logic signed [PW:0]   acc_sum;
   logic                 accept;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic signed [SW-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RMUL: begin
            mul_a = MA'(d_ff);
            mul_b = MB'(spm_ff);
         end
         ST_RLOAD: begin
            // quotient estimate of the integer delay by the store length
            mul_a = MA'(r_full[35:16]);
            mul_b = MB'(RECIP_Q20);
         end
         ST_QMUL: begin
            mul_a = MA'(prod_ff[2*DELAY_W-1:DELAY_W]);
            mul_b = MB'(DEPTH_R);
         end
         ST_IMUL: begin
            mul_a = MA'($signed({rd_ff[SW-1], rd_ff}) - $signed({a_ff[SW-1], a_ff}));
            mul_b = MB'(f_ff);
         end
         ST_EMUL: begin
            mul_a = MA'(div_num_ff);
            mul_b = MB'(LOG2_1000_Q16);
         end
         ST_EXPM: begin
            mul_a = MA'(m_ff);
            mul_b = frac_ff[EXP_BITS-1] ? MB'(exp2_neg(cnt_ff[3:0])) : MB'(ONE_Q16);
         end
         ST_GMUL: begin
            mul_a = MA'(g_ff);
            mul_b = MB'(y_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      r_full = (prod_ff[35:0] < 36'd65536) ? 36'd65536 : prod_ff[35:0];
      // the estimate is short by at most one store length
      mod_raw = {1'b0, rint_ff} - {1'b0, prod_ff[DELAY_W-1:0]};
      mod_fix = (mod_raw >= DEPTH_R) ? mod_raw - DEPTH_R : mod_raw;
      pos_raw = {2'b00, wp_ff} - {1'b0, rem_ff} - {{(AW + 1){1'b0}}, (rfrac_ff != 16'd0)};
      pos_wrap = pos_raw[AW+1] ? pos_raw + DEPTH_X : pos_raw;
      i1_next = pos_wrap[AW-1:0];
      interp_sh = prod_ff >>> 16;
      y_sum = (SW + 1)'(a_ff) + interp_sh[SW:0];
      div_trial = {div_rem_ff, div_num_ff[35]};
      m_round = prod_ff[32:0] + 33'd32768;
      g_mag = {m_ff, 4'b0000} >> n_ff;
      out_sh = prod_ff >>> 20;
      acc_sum = (PW + 1)'(x_ff) + (PW + 1)'(out_sh);
   end

   always_comb begin
      mem_we = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = acc_sum[SW-1:0];
      mem_raddr = i1_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_ACC) begin
         mem_we = 1'b1;
         if (acc_sum > SMAX) begin
            mem_wdata = SMAX[SW-1:0];
         end else if (acc_sum < SMIN) begin
            mem_wdata = SMIN[SW-1:0];
         end
      end
      if (state_ff == ST_RDB) begin
         mem_raddr = i2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= store_mem[mem_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == CMD_CLEAR) ? ST_CLEAR : ST_RMUL;
            end
         end
         ST_RMUL:   state_in = ST_RLOAD;
         ST_RLOAD:  state_in = ST_QMUL;
         ST_QMUL:   state_in = ST_MOD;
         ST_MOD:    state_in = ST_ADDR;
         ST_ADDR:   state_in = ST_RDA;
         ST_RDA:    state_in = ST_RDB;
         ST_RDB:    state_in = ST_IMUL;
         ST_IMUL:   state_in = ST_INTERP;
         ST_INTERP: begin
            if (mode_ff == MODE_DIRECT || coef_ff == '0) begin
               state_in = ST_GMUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:    if (cnt_ff == 6'd0) state_in = ST_EMUL;
         ST_EMUL:   state_in = ST_ELOAD;
         ST_ELOAD:  state_in = ST_EXPM;
         ST_EXPM:   state_in = ST_EXPR;
         ST_EXPR:   state_in = (cnt_ff == 6'(EXP_BITS - 1)) ? ST_GAIN : ST_EXPM;
         ST_GAIN:   state_in = ST_GMUL;
         ST_GMUL:   state_in = ST_ACC;
         ST_ACC:    state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         wp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         spm_ff <= SAMPLES_PER_MS_RESET;
         max_delay_ff <= '0;
         mode_ff <= MODE_DECAY;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES_PER_MS: spm_ff <= csr_wdata[15:0];
               CSR_MAX_DELAY_MS:   max_delay_ff <= csr_wdata[DELAY_W-1:0];
               CSR_GAIN_MODE:      mode_ff <= csr_wdata[0];
               default:            ;
            endcase
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= (clr_addr_ff == LAST_ADDR) ? '0 : clr_addr_ff + AW'(1);
         end
         if (accept && req_command == CMD_CLEAR) begin
            wp_ff <= '0;
            clr_addr_ff <= '0;
         end
         if (state_ff == ST_ACC) begin
            wp_ff <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            x_ff <= req_sample_in;
            d_ff <= (req_delay_ms > max_delay_ff) ? max_delay_ff : req_delay_ms;
            coef_ff <= req_coef;
         end
         ST_RLOAD: begin
            rint_ff <= r_full[35:16];
            rfrac_ff <= r_full[15:0];
         end
         ST_MOD: rem_ff <= mod_fix[AW:0];
         ST_ADDR: begin
            i1_ff <= i1_next;
            i2_ff <= (i1_next == LAST_ADDR) ? '0 : i1_next + AW'(1);
            f_ff <= {1'b0, 16'd0 - rfrac_ff};
         end
         ST_RDB: a_ff <= rd_ff;
         ST_INTERP: begin
            y_ff <= y_sum[SW-1:0];
            g_ff <= (mode_ff == MODE_DIRECT) ? coef_ff : '0;
            mag_ff <= coef_ff[COEF_W-1] ? 24'(-coef_ff) : 24'(coef_ff);
            div_num_ff <= {d_ff, 16'd0};
            div_rem_ff <= '0;
            cnt_ff <= 6'd35;
         end
         ST_DIV: begin
            if (div_trial >= mag_ff) begin
               div_rem_ff <= 23'(div_trial - mag_ff);
               div_num_ff <= {div_num_ff[34:0], 1'b1};
            end else begin
               div_rem_ff <= div_trial[22:0];
               div_num_ff <= {div_num_ff[34:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
         end
         ST_ELOAD: begin
            nbig_ff <= (prod_ff[PW-1:32] > (PW - 32)'(MAX_EXP_SHIFT));
            n_ff <= prod_ff[37:32];
            frac_ff <= prod_ff[31:32-EXP_BITS];
            m_ff <= ONE_Q16;
            cnt_ff <= '0;
         end
         ST_EXPR: begin
            m_ff <= m_round[32:16];
            frac_ff <= {frac_ff[EXP_BITS-2:0], 1'b0};
            cnt_ff <= cnt_ff + 6'd1;
         end
         ST_GAIN: begin
            if (nbig_ff) begin
               g_ff <= '0;
            end else if (coef_ff[COEF_W-1]) begin
               g_ff <= -COEF_W'(g_mag);
            end else begin
               g_ff <= COEF_W'(g_mag);
            end
         end
         ST_ACC: acc_ff <= mem_wdata;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_ff <= acc_ff;
            end
         end
         default: ;
      endcase
   end

endmodule
